// File: hdl/assert_macros.svh
// Assertion macros shared by the frame receiver RTL.
// Needs clock and reset signals in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HTFR_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HTFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/htfr_pkg.sv
// Package for the header/trailer frame receiver: codes, byte constants, structs.
// No dependencies.
`timescale 1ns / 1ps

package htfr_pkg;

   localparam int BYTE_W = 8;
   localparam int MODE_W = 2;

   typedef logic [BYTE_W-1:0] byte_type;

   // Item operation codes; code 3 has no meaning and acts as a status poll.
   typedef enum logic [MODE_W-1:0] {
      MODE_BYTE    = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_READ    = 2'd2
   } mode_type;

   localparam byte_type HDR_FIRST  = 8'h43;
   localparam byte_type HDR_SECOND = 8'h47;
   localparam byte_type TRL_FIRST  = 8'h53;
   localparam byte_type TRL_SECOND = 8'h57;

   // Buffer write request; entry 0 lives in its own register.
   typedef struct packed {
      logic     mem_we;
      byte_type mem_data;
      logic     pos0_we;
      byte_type pos0_data;
   } buf_wr_type;

   // Per-item status carried to the result stage.
   typedef struct packed {
      logic     frame_done;
      byte_type byte_count;
      logic     is_read;
   } status_type;

endpackage

// File: hdl/htfr_ifs.sv
// Handshake channel interfaces for the frame receiver (request, response, csr).
// Depends on htfr_pkg.
`timescale 1ns / 1ps

interface htfr_req_if import htfr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   byte_type            rx_byte;
   byte_type            read_index;

   modport source (output valid, mode, rx_byte, read_index, input ready);
   modport sink   (input valid, mode, rx_byte, read_index, output ready);
endinterface

interface htfr_rsp_if import htfr_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     frame_done;
   byte_type byte_count;
   byte_type read_data;

   modport source (output valid, frame_done, byte_count, read_data, input ready);
   modport sink   (input valid, frame_done, byte_count, read_data, output ready);
endinterface

interface htfr_csr_if import htfr_pkg::*; ();
   logic valid;
   logic ready;
   logic framed_mode;

   modport source (output valid, framed_mode, input ready);
   modport sink   (input valid, framed_mode, output ready);
endinterface

// File: hdl/htfr_parser.sv
// Frame parser: write count, done flag, header/trailer tracking, buffer writes.
// Depends on htfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htfr_parser import htfr_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [MODE_W-1:0] mode,
   input  byte_type          rx_byte,
   input  logic              framed_mode,
   output buf_wr_type        wr,
   output logic [AW-1:0]     wr_addr,
   output status_type        status
);

   logic [AW-1:0] wc_ff, wc_in;
   logic          done_ff, done_in;
   logic          hs_ff, hs_in;
   logic          ts_ff, ts_in;
   logic          inf_ff, inf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff   <= '0;
         done_ff <= 1'b0;
         hs_ff   <= 1'b0;
         ts_ff   <= 1'b0;
         inf_ff  <= 1'b0;
      end else if (accept) begin
         wc_ff   <= wc_in;
         done_ff <= done_in;
         hs_ff   <= hs_in;
         ts_ff   <= ts_in;
         inf_ff  <= inf_in;
      end
   end

   always_comb begin
      wc_in   = wc_ff;
      done_in = done_ff;
      hs_in   = hs_ff;
      ts_in   = ts_ff;
      inf_in  = inf_ff;
      wr      = '0;
      wr_addr = '0;
      unique case (mode)
         MODE_BYTE: begin
            if (!done_ff) begin
               if (framed_mode) begin
                  // header: 0x43 arms, 0x47 after it restarts the frame
                  if (!hs_ff && rx_byte == HDR_FIRST) begin
                     hs_in = 1'b1;
                  end else if (hs_ff && rx_byte == HDR_SECOND) begin
                     wr.pos0_we   = 1'b1;
                     wr.pos0_data = HDR_FIRST;
                     wc_in        = AW'(1);
                     inf_in       = 1'b1;
                  end else begin
                     hs_in = 1'b0;
                  end
                  if (inf_in) begin
                     // overflow restarts at position 0
                     if (wc_in >= AW'(DEPTH - 1)) begin
                        ts_in  = 1'b0;
                        inf_in = 1'b0;
                        wc_in  = '0;
                     end
                     if (wc_in == '0) begin
                        wr.pos0_we   = 1'b1;
                        wr.pos0_data = rx_byte;
                     end else begin
                        wr.mem_we   = 1'b1;
                        wr.mem_data = rx_byte;
                        wr_addr     = wc_in;
                     end
                     wc_in = wc_in + AW'(1);
                     if (!ts_in && rx_byte == TRL_FIRST) begin
                        ts_in = 1'b1;
                     end else if (ts_in && rx_byte == TRL_SECOND) begin
                        done_in = 1'b1;
                        wc_in   = '0;
                        inf_in  = 1'b0;
                        ts_in   = 1'b0;
                     end else begin
                        ts_in = 1'b0;
                     end
                  end
               end else begin
                  if (wc_ff == '0) begin
                     wr.pos0_we   = 1'b1;
                     wr.pos0_data = rx_byte;
                  end else begin
                     wr.mem_we   = 1'b1;
                     wr.mem_data = rx_byte;
                     wr_addr     = wc_ff;
                  end
                  wc_in = (wc_ff == AW'(DEPTH - 1)) ? '0 : wc_ff + AW'(1);
               end
            end
         end
         MODE_RELEASE: begin
            done_in = 1'b0;
            wc_in   = '0;
         end
         default: begin
         end
      endcase
      // buffer is written only by an accepted item
      if (!accept) begin
         wr      = '0;
         wr_addr = '0;
      end
      status.frame_done = done_in;
      status.byte_count = done_in ? '0 : BYTE_W'(wc_in);
      status.is_read    = (mode == MODE_READ);
   end

   `HTFR_ASSERT(a_done_outside_frame, done_ff, !inf_ff, "done flag set inside a frame")
   `HTFR_ASSERT_NEXT(a_done_blocks_bytes, accept && mode == MODE_BYTE && done_ff,
                     done_ff && $stable(wc_ff), "byte changed state while done")

endmodule

// File: hdl/htfr_buffer.sv
// Frame buffer: synchronous RAM for entries 1..DEPTH-1, register for entry 0,
// power-on clearing sweep. Depends on htfr_pkg.
`timescale 1ns / 1ps

module htfr_buffer import htfr_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  buf_wr_type    wr,
   input  logic [AW-1:0] wr_addr,
   input  logic          rd_en,
   input  byte_type      rd_index,
   output byte_type      rd_data,
   output logic          busy
);

   localparam int RW = AW + 6;

   byte_type      mem [DEPTH];
   byte_type      mem_rd_ff;
   byte_type      pos0_ff;
   byte_type      pos0_cap_ff;
   logic          rd_zero_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic          clr_busy_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   byte_type      mem_wd;
   logic [AW-1:0] rd_addr;

   // index modulo DEPTH by restoring subtraction (at most 63 multiples)
   function automatic logic [AW-1:0] wrap_index(input byte_type idx);
      logic [RW-1:0] r;
      r = RW'(idx);
      for (int s = 5; s >= 0; s--) begin
         if (r >= (RW'(DEPTH) << s)) begin
            r = r - (RW'(DEPTH) << s);
         end
      end
      return r[AW-1:0];
   endfunction

   assign rd_addr = wrap_index(rd_index);
   assign mem_we  = clr_busy_ff | wr.mem_we;
   assign mem_wa  = clr_busy_ff ? clr_cnt_ff : wr_addr;
   assign mem_wd  = clr_busy_ff ? '0 : wr.mem_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_addr];
         pos0_cap_ff <= pos0_ff;
         rd_zero_ff  <= (rd_addr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos0_ff     <= '0;
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         if (wr.pos0_we) begin
            pos0_ff <= wr.pos0_data;
         end
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   assign rd_data = rd_zero_ff ? pos0_cap_ff : mem_rd_ff;
   assign busy    = clr_busy_ff;

endmodule

// File: hdl/htfr_outq.sv
// Result stage: holding register behind the buffer read plus an output register.
// Depends on htfr_pkg, htfr_ifs and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htfr_outq import htfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_accept,
   input  status_type in_status,
   input  byte_type   in_rdata,
   output logic       in_room,
   htfr_rsp_if.source rsp_bus
);

   logic       s1_valid_ff;
   status_type s1_status_ff;
   logic       o_valid_ff;
   logic       o_done_ff;
   byte_type   o_count_ff;
   byte_type   o_rdata_ff;
   logic       s1_move;

   assign s1_move = s1_valid_ff && (!o_valid_ff || rsp_bus.ready);
   assign in_room = !s1_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= in_accept || (s1_valid_ff && !s1_move);
         o_valid_ff  <= s1_move || (o_valid_ff && !rsp_bus.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_status_ff <= in_status;
      end
      if (s1_move) begin
         o_done_ff  <= s1_status_ff.frame_done;
         o_count_ff <= s1_status_ff.byte_count;
         o_rdata_ff <= s1_status_ff.is_read ? in_rdata : '0;
      end
   end

   assign rsp_bus.valid      = o_valid_ff;
   assign rsp_bus.frame_done = o_done_ff;
   assign rsp_bus.byte_count = o_count_ff;
   assign rsp_bus.read_data  = o_rdata_ff;

   `HTFR_ASSERT_NEXT(a_s1_fills_empty_out, s1_valid_ff && !o_valid_ff, o_valid_ff,
                     "held item did not advance into empty output register")

endmodule

// File: hdl/header_trailer_frame_receiver.sv
// Top level of the header/trailer byte frame receiver.
// Depends on htfr_pkg, htfr_ifs, htfr_parser, htfr_buffer, htfr_outq, assert_macros.svh.
//
//   channel   port      dir   payload
//   request   req_bus   in    mode, rx_byte, read_index
//   response  rsp_bus   out   frame_done, byte_count, read_data
//   config    csr_bus   in    framed_mode (always ready)
//
// One item per cycle while req_bus.ready is high; a result goes through the
// buffer read and holding registers, then the output register.
// After reset the buffer RAM is swept to zero, one entry a cycle, with
// req_bus.ready low until the sweep ends. Config writes are taken throughout.
// A stalled response holds one result plus one more in the holding stage;
// outside the sweep, req_bus.ready drops only when both are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module header_trailer_frame_receiver import htfr_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   htfr_req_if.sink   req_bus,
   htfr_rsp_if.source rsp_bus,
   htfr_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(DEPTH);

   logic          framed_mode_ff;
   logic          accept;
   logic          clr_busy;
   logic          out_room;
   buf_wr_type    wr;
   logic [AW-1:0] wr_addr;
   status_type    status;
   byte_type      rd_data;
   logic          rd_en;

   // config register; the user must write it only while the block is idle, the block itself does not enforce it
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         framed_mode_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         framed_mode_ff <= csr_bus.framed_mode;
      end
   end

   assign req_bus.ready = !clr_busy && out_room;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rd_en         = accept && (req_bus.mode == MODE_READ);

   // All parser state sits in flops and settles at the accept edge; the RAM
   // write of one item lands before the next item's read, so a read right
   // after a write to the same entry needs no forwarding.
   htfr_parser #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_bus.mode),
      .rx_byte     (req_bus.rx_byte),
      .framed_mode (framed_mode_ff),
      .wr          (wr),
      .wr_addr     (wr_addr),
      .status      (status)
   );

   // Entry 0 is a separate register so that a completed header can place
   // 0x43 at position 0 and 0x47 at position 1 in the same cycle.
   htfr_buffer #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_buffer (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .wr_addr  (wr_addr),
      .rd_en    (rd_en),
      .rd_index (req_bus.read_index),
      .rd_data  (rd_data),
      .busy     (clr_busy)
   );

   htfr_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_status (status),
      .in_rdata  (rd_data),
      .in_room   (out_room),
      .rsp_bus   (rsp_bus)
   );

   `HTFR_ASSERT(a_no_item_while_clearing, clr_busy, !req_bus.ready,
                "item port ready during buffer clear")
   `HTFR_ASSERT(a_done_zero_count, rsp_bus.valid && rsp_bus.frame_done,
                rsp_bus.byte_count == '0, "nonzero count reported with frame done")

endmodule

// File: test/header_trailer_frame_receiver_test.sv
// Self-checking bench for header_trailer_frame_receiver: raw capture, framed parsing,
// overflow, release and buffer reads, with random sender gaps and receiver stalls.
// Depends on htfr_pkg, the htfr channel interfaces and the receiver RTL.
`timescale 1ns / 1ps

module header_trailer_frame_receiver_test import htfr_pkg::*;;

   localparam int DEPTH          = 256;
   localparam int CLOCK_PERIOD   = 4;
   localparam int HOLD_CYCLES    = 60;    // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES   = 8;     // result path is two stages deep
   localparam int WATCHDOG_LIMIT = 2000;  // sweep + hold-off + gaps, several times over

   // Code 3 is not decoded by the block: it only reports status.
   localparam logic [MODE_W-1:0] MODE_POLL = 2'd3;

   // Receiver ready patterns.
   typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_style_type;

   typedef struct {
      logic     frame_done;
      byte_type byte_count;
      byte_type read_data;
   } rx_status_type;

   // Tracks the receiver state item by item and holds the status words still owed.
   class frame_status_board;
      byte_type      frame_mem [DEPTH];
      int            next_pos;
      bit            done_flag, hdr_armed, trl_armed, in_frame, framed;
      rx_status_type pending_status [$];
      int            failures, checked, frames_done, overflows, restarts;

      function new();
         foreach (frame_mem[i]) frame_mem[i] = '0;
      endfunction

      function void note_item(logic [MODE_W-1:0] mode, byte_type data, byte_type rd_index);
         rx_status_type st;
         st.read_data = '0;
         case (mode)
            MODE_BYTE: begin
               if (!done_flag && !framed) begin
                  frame_mem[next_pos] = data;
                  next_pos = (next_pos == DEPTH - 1) ? 0 : next_pos + 1;
               end else if (!done_flag) begin
                  // header: armed flag survives a match, so another 0x47 restarts
                  if (!hdr_armed && data == HDR_FIRST) begin
                     hdr_armed = 1'b1;
                  end else if (hdr_armed && data == HDR_SECOND) begin
                     frame_mem[0] = HDR_FIRST;
                     next_pos = 1;
                     in_frame = 1'b1;
                     restarts++;
                  end else begin
                     hdr_armed = 1'b0;
                  end
                  if (in_frame) begin
                     if (next_pos >= DEPTH - 1) begin
                        // overflow: frame dropped, byte lands at 0
                        trl_armed = 1'b0;
                        in_frame = 1'b0;
                        next_pos = 0;
                        overflows++;
                     end
                     frame_mem[next_pos] = data;
                     next_pos = (next_pos + 1) % DEPTH;
                     if (!trl_armed && data == TRL_FIRST) begin
                        trl_armed = 1'b1;
                     end else if (trl_armed && data == TRL_SECOND) begin
                        done_flag = 1'b1;
                        next_pos = 0;
                        in_frame = 1'b0;
                        trl_armed = 1'b0;
                        frames_done++;
                     end else begin
                        trl_armed = 1'b0;
                     end
                  end
               end
            end
            MODE_RELEASE: begin
               done_flag = 1'b0;
               next_pos = 0;
            end
            MODE_READ: st.read_data = frame_mem[rd_index % DEPTH];
            default: ;
         endcase
         st.frame_done = done_flag;
         st.byte_count = done_flag ? '0 : byte_type'(next_pos);
         pending_status.push_back(st);
      endfunction

      function void check_status(logic done, byte_type count, byte_type rdata);
         rx_status_type want;
         if (pending_status.size() == 0) begin
            $error("result with nothing outstanding: frame_done=%0d byte_count=%0d",
                   done, count);
            $error("result with nothing outstanding: read_data=%0d", rdata);
            failures++;
            return;
         end
         want = pending_status.pop_front();
         checked++;
         if (done !== want.frame_done) begin
            $error("frame_done: expected %0d, actual %0d", want.frame_done, done);
            failures++;
         end
         if (count !== want.byte_count) begin
            $error("byte_count: expected %0d, actual %0d", want.byte_count, count);
            failures++;
         end
         if (rdata !== want.read_data) begin
            $error("read_data: expected 0x%02h, actual 0x%02h", want.read_data, rdata);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   htfr_req_if req_bus ();
   htfr_rsp_if rsp_bus ();
   htfr_csr_if csr_bus ();

   frame_status_board sb;

   bit           hold_req;       // raised by the stimulus, cleared by the receiver after the hold
   int           burst_left;
   int           items_sent;
   int           idle_cycles;
   int           input_stalls;
   int           style_left;
   int           stall_phase;
   rx_style_type rsp_style;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   header_trailer_frame_receiver #(.DEPTH(DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Handshakes are sampled at the falling edge: the values there are the ones
   // the block sees at the next rising edge, free of same-step ordering.
   always @(negedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_status(rsp_bus.frame_done, rsp_bus.byte_count, rsp_bus.read_data);
         if (req_bus.valid && !req_bus.ready)
            input_stalls++;
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // Watchdog: too long without any item moving on any channel.
   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // Result side: ready follows one of four patterns, each picked at random for a random stretch;
   // on request it holds off for a long stretch so the block backs up.
   initial begin : rsp_backpressure
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            if (style_left == 0) begin
               rsp_style = rx_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(16, 96);
            end
            style_left--;
            stall_phase++;
            case (rsp_style)
               RX_OPEN:     rsp_bus.ready <= 1'b1;
               RX_RANDOM:   rsp_bus.ready <= ($urandom_range(0, 9) < 7);
               RX_PERIODIC: rsp_bus.ready <= (stall_phase % 4 != 0);
               default:     rsp_bus.ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   // Random byte, sized for the item fields.
   function automatic byte_type rand_byte(input int hi);
      return byte_type'($urandom_range(0, hi));
   endfunction

   // Offers one item and returns at the rising edge that took it. The sender
   // works in bursts; no gaps while the receiver hold-off is running.
   task automatic send_item(input logic [MODE_W-1:0] mode, input byte_type data,
                            input byte_type rd_index);
      bit fire;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
         if (!hold_req) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= mode;
      req_bus.rx_byte    <= data;
      req_bus.read_index <= rd_index;
      do begin
         @(negedge clock);
         fire = req_bus.ready;
         @(posedge clock);
      end while (!fire);
      sb.note_item(mode, data, rd_index);
      items_sent++;
   endtask

   task automatic send_byte(input byte_type data);
      send_item(MODE_BYTE, data, rand_byte(255));
   endtask

   task automatic send_read(input byte_type rd_index);
      send_item(MODE_READ, rand_byte(255), rd_index);
   endtask

   // Drops valid and waits until every owed status word has come back.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_status.size() != 0) @(posedge clock);
   endtask

   // Mode register is only touched with the block idle.
   task automatic write_mode(input logic framed);
      bit fire;
      wait_idle();
      csr_bus.valid       <= 1'b1;
      csr_bus.framed_mode <= framed;
      do begin
         @(negedge clock);
         fire = csr_bus.ready;
         @(posedge clock);
      end while (!fire);
      csr_bus.valid <= 1'b0;
      sb.framed = framed;
   endtask

   // Header, random payload, then mostly a proper trailer, sometimes a broken one.
   task automatic send_frame(input int len);
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      repeat (len) send_byte(rand_byte(255));
      send_byte(TRL_FIRST);
      send_byte(($urandom_range(0, 4) != 0) ? TRL_SECOND : rand_byte(255));
   endtask

   // Mixed traffic: mostly complete frames followed by reads and a release,
   // plus broken header/trailer sequences, random items and stray reads.
   task automatic run_traffic(input int n);
      int stop_at;
      int pick;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_frame($urandom_range(0, 12));
            repeat ($urandom_range(1, 4)) send_read(rand_byte(15));
            if ($urandom_range(0, 3) == 0)
               send_byte(rand_byte(255));   // dropped if the frame closed
            if ($urandom_range(0, 4) == 0)
               send_item(MODE_POLL, rand_byte(255), rand_byte(255));
            send_item(MODE_RELEASE, rand_byte(255), rand_byte(255));
         end else if (pick < 65) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
               // second 0x43 disarms the header
               send_byte(HDR_FIRST);
               send_byte(HDR_FIRST);
               send_byte(HDR_SECOND);
            end else if (pick == 1) begin
               // repeated 0x47 restarts the frame
               send_byte(HDR_FIRST);
               send_byte(HDR_SECOND);
               send_byte(HDR_SECOND);
            end else if (pick == 2) begin
               send_byte(TRL_FIRST);
               send_byte(rand_byte(255));
            end else begin
               send_byte(HDR_FIRST);
               send_byte(rand_byte(255));
            end
         end else if (pick < 85) begin
            send_item(MODE_W'($urandom_range(0, 3)), rand_byte(255), rand_byte(255));
         end else begin
            send_read(rand_byte(255));
         end
      end
   endtask

   initial begin : stimulus
      byte_type b;
      sb = new();
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.mode        <= MODE_BYTE;
      req_bus.rx_byte     <= '0;
      req_bus.read_index  <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.framed_mode <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed, raw capture: cleared buffer at both ends, byte extremes,
      // status poll, release.
      write_mode(1'b0);
      send_read(8'h00);
      send_read(8'hFF);
      send_item(MODE_POLL, 8'hFF, 8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_read(8'h01);
      send_item(MODE_RELEASE, 8'h00, 8'h00);

      // Directed, framed: header disarm, restart on repeated 0x47, trailer,
      // dropped byte while done, reads of the frame, release.
      write_mode(1'b1);
      send_byte(HDR_FIRST);
      send_byte(HDR_FIRST);     // disarms
      send_byte(HDR_SECOND);    // no frame
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);    // frame opens
      send_byte(HDR_SECOND);    // header still armed: restart
      send_byte(8'hA5);
      send_byte(TRL_FIRST);
      send_byte(TRL_SECOND);    // frame complete
      send_byte(8'h5A);         // ignored while done
      send_read(8'h00);
      send_read(8'h02);
      send_item(MODE_POLL, 8'h00, 8'h00);
      send_item(MODE_RELEASE, 8'hFF, 8'hFF);
      send_byte(TRL_FIRST);     // outside any frame
      send_read(8'hFF);

      // Raw capture of DEPTH + 8 items, mostly bytes with some reads mixed in.
      write_mode(1'b0);
      repeat (DEPTH + 8) begin
         if ($urandom_range(0, 11) == 0)
            send_read(rand_byte(255));
         else
            send_byte(rand_byte(255));
      end

      // Framed traffic, opening with the long receiver hold-off.
      write_mode(1'b1);
      hold_req = 1'b1;
      run_traffic(60);

      // Overflow: a frame with no header or trailer bytes in its payload runs
      // off the end of the buffer; the overflowing byte is sometimes a
      // trailer byte, and 0x53 there leaves the trailer state behind.
      send_item(MODE_RELEASE, rand_byte(255), rand_byte(255));
      send_byte(8'h00);
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      repeat (DEPTH - 3) begin
         do
            b = rand_byte(255);
         while (b == HDR_FIRST || b == HDR_SECOND || b == TRL_FIRST || b == TRL_SECOND);
         send_byte(b);
      end
      b = rand_byte(255);
      if ($urandom_range(0, 2) == 0)
         b = TRL_FIRST;
      else if ($urandom_range(0, 1) == 0)
         b = TRL_SECOND;
      send_byte(b);
      send_read(8'h00);
      send_read(8'hFE);
      send_read(rand_byte(255));
      run_traffic(60);

      // Switch modes with parser state left as it is.
      write_mode(1'b0);
      run_traffic(40);
      write_mode(1'b1);
      run_traffic(40);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d items accepted, %0d status words checked",
               items_sent, sb.checked);
      $display("summary: %0d frames closed, %0d header restarts, %0d overflows, %0d stalls",
               sb.frames_done, sb.restarts, sb.overflows, input_stalls);
      if (sb.failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/htfr_pkg.sv
hdl/htfr_ifs.sv
hdl/htfr_parser.sv
hdl/htfr_buffer.sv
hdl/htfr_outq.sv
hdl/header_trailer_frame_receiver.sv
test/header_trailer_frame_receiver_test.sv
